[design/lkvc_pkg.sv]
// Shared constants, types and command codes for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [CMP_W-1:0]  ENTRIES_CMP = CMP_W'(ENTRIES);
    localparam logic [RANK_W:0]   FILL_RANK  = (RANK_W+1)'(ENTRIES);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] SET_VALUE  = '0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the input transfer into the request registers
        logic lookup;    // register match, free slot and victim selection
        logic commit;    // apply the update and load the result register
    } lkvc_cmd_t;

endpackage

[design/lkvc_ctrl.sv]
// Controller state machine: input and output handshakes and step sequencing.
module lkvc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lkvc_pkg::lkvc_cmd_t cmd
);
    import lkvc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    // Accept one request at a time; a waiting result does not block intake
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Drive the datapath commands
    always_comb
    begin
        cmd.capture = accept;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.commit  = (state_reg == ST_COMMIT) && out_free;
    end

    // Advance through lookup and commit
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer, load on commit
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_lookup_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |=> state_reg == ST_COMMIT)
        else $error("lookup step not followed by commit step");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_no_commit_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !cmd.commit)
        else $error("commit overwrote a result still waiting");

endmodule

[design/lkvc_datapath.sv]
// Datapath: entry store, key match, recency ranks, occupancy and result register.
module lkvc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkvc_pkg::lkvc_cmd_t           cmd,
    input  logic                          capacity_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    capacity_wdata,
    input  logic                          mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] value,
    output logic                          hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
    import lkvc_pkg::*;

    // Configuration
    logic [CAP_W-1:0]  capacity_reg;

    // Request registers
    logic              mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;

    // Entry store
    logic [KEY_W-1:0]  ent_key_reg   [ENTRIES];
    logic [DATA_W-1:0] ent_value_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;

    // Lookup results
    logic              found_reg,   found_next;
    logic [DATA_W-1:0] found_val_reg, found_val_next;
    logic [IDX_W-1:0]  tgt_idx_reg, tgt_idx_next;
    logic [RANK_W:0]   tgt_rank_reg, tgt_rank_next;
    logic              upd_reg,     upd_next;
    logic              wr_key_reg,  wr_key_next;
    logic              wr_val_reg,  wr_val_next;
    logic              fill_reg,    fill_next;

    // Result register
    logic              out_hit_reg,  out_hit_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    // Match scratch
    logic [ENTRIES-1:0] match;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    logic              old_any;
    logic [IDX_W-1:0]  old_idx;
    logic [CMP_W-1:0]  cap_sat;
    logic              room;
    logic [CNT_W-1:0]  occ_m1;

    // Capacity register; the limit used is saturated at the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (capacity_we)
        begin
            capacity_reg <= capacity_wdata;
        end
    end

    assign cap_sat = (CMP_W'(capacity_reg) > ENTRIES_CMP) ? ENTRIES_CMP : CMP_W'(capacity_reg);
    assign room    = CMP_W'(occ_reg) < cap_sat;
    assign occ_m1  = occ_reg - CNT_W'(1);

    // Capture the request on its input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    // Compare all keys; pick lowest matching, lowest free and the oldest entry
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        old_any  = 1'b0;
        old_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (ent_key_reg[i] == key_reg);
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (occ_reg != '0) &&
                ((RANK_W+1)'(rank_reg[i]) == (RANK_W+1)'(occ_m1)))
            begin
                old_any = 1'b1;
                old_idx = IDX_W'(i);
            end
        end
    end

    // Decide the update to apply
    always_comb
    begin
        found_next     = hit_any;
        found_val_next = ent_value_reg[hit_idx];
        tgt_idx_next   = hit_idx;
        tgt_rank_next  = {1'b0, rank_reg[hit_idx]};
        upd_next       = 1'b0;
        wr_key_next    = 1'b0;
        wr_val_next    = 1'b0;
        fill_next      = 1'b0;
        priority if (hit_any)
        begin
            upd_next    = 1'b1;
            wr_val_next = (mode_reg == MODE_SET);
        end
        else if (mode_reg == MODE_SET && room)
        begin
            tgt_idx_next  = free_idx;
            tgt_rank_next = FILL_RANK;
            upd_next      = free_any;
            wr_key_next   = free_any;
            wr_val_next   = free_any;
            fill_next     = free_any;
        end
        else if (mode_reg == MODE_SET)
        begin
            tgt_idx_next  = old_idx;
            tgt_rank_next = (RANK_W+1)'(occ_m1);
            upd_next      = old_any;
            wr_key_next   = old_any;
            wr_val_next   = old_any;
        end
        else
        begin
            // get miss: leave the store as it is
            upd_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            found_reg     <= found_next;
            found_val_reg <= found_val_next;
            tgt_idx_reg   <= tgt_idx_next;
            tgt_rank_reg  <= tgt_rank_next;
            wr_key_reg    <= wr_key_next;
            wr_val_reg    <= wr_val_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            upd_reg <= upd_next;
        end
    end

    // Age younger entries, make the target most recent, fill a slot
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.commit && upd_reg)
            begin
                if (IDX_W'(i) == tgt_idx_reg)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && ({1'b0, rank_reg[i]} < tgt_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (cmd.commit && upd_reg && fill_reg)
        begin
            valid_next[tgt_idx_reg] = 1'b1;
            occ_next                = occ_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Write key and value of the target entry
    always_ff @(posedge clk)
    begin
        if (cmd.commit && upd_reg && wr_key_reg)
        begin
            ent_key_reg[tgt_idx_reg] <= key_reg;
        end
        if (cmd.commit && upd_reg && wr_val_reg)
        begin
            ent_value_reg[tgt_idx_reg] <= value_reg;
        end
    end

    // Load the result register
    always_comb
    begin
        out_hit_next = found_reg;
        if (mode_reg == MODE_SET)
        begin
            out_data_next = SET_VALUE;
        end
        else if (found_reg)
        begin
            out_data_next = found_val_reg;
        end
        else
        begin
            out_data_next = MISS_VALUE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg  <= out_hit_next;
            out_data_reg <= out_data_next;
        end
    end

    assign hit        = out_hit_reg;
    assign read_value = out_data_reg;

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(valid_reg)) == occ_reg)
        else $error("occupancy differs from number of valid entries");

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= ENTRIES_CMP)
        else $error("occupancy above entry count");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && upd_reg && fill_reg |=> occ_reg == $past(occ_reg) + CNT_W'(1))
        else $error("fill did not grow occupancy");

endmodule

[design/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache: controller plus datapath.
// A request steps through capture, lookup and commit; the commit step loads the
// result register. A new request is taken only after the previous commit;
// a finished result waits in the output register while the next request is taken.
// Reset: asynchronous active-low; clears valid bits, ranks, occupancy and the
// handshake state, and sets capacity to 16. Keys and values are not reset.
module lru_key_value_cache_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capacity_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    capacity_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
    import lkvc_pkg::*;

    lkvc_cmd_t cmd;

    // Sequence the request through lookup and commit
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Hold entries and compute the result
    lkvc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .mode           (mode),
        .key            (key),
        .value          (value),
        .hit            (hit),
        .read_value     (read_value)
    );

endmodule
